@@ src/obr_pkg.sv @@
// shared types and constants of the oriented box ray slab test
package obr_pkg;

    localparam int CW        = 21;
    localparam int TW        = 32;
    localparam int PACK_W    = 3 * CW;
    localparam int AXES      = 3;
    localparam int DIV_STEPS = TW - 1;
    localparam int QSH       = 25;
    localparam int SAT_SH    = DIV_STEPS - QSH;
    localparam int AXIS_LAT  = DIV_STEPS + 4;
    localparam int DATA_W    = 64;
    localparam int ADDR_LSB  = 3;
    localparam int ADDR_W    = ADDR_LSB + 3;

    localparam logic signed [TW-1:0] T_MAX = {1'b0, {(TW-1){1'b1}}};
    localparam logic signed [TW-1:0] T_MIN = {1'b1, {(TW-1){1'b0}}};

    typedef enum logic [ADDR_W-ADDR_LSB-1:0] {
        REG_MIN_CORNER,
        REG_MAX_CORNER,
        REG_NORMAL0,
        REG_NORMAL1,
        REG_NORMAL2,
        REG_BOX_VALID
    } t_reg;

    typedef logic signed [CW-1:0] t_comp;
    typedef t_comp t_vec3 [3];

    typedef struct packed {
        logic                 par;
        logic                 par_ok;
        logic signed [TW-1:0] t1;
        logic signed [TW-1:0] t2;
    } t_axr;

endpackage

@@ src/obr_if.sv @@
// ray and result channel interfaces
interface obr_ray_if import obr_pkg::*; ();
    logic  valid;
    logic  ready;
    t_comp origin_x;
    t_comp origin_y;
    t_comp origin_z;
    t_comp direction_x;
    t_comp direction_y;
    t_comp direction_z;

    modport source (output valid, origin_x, origin_y, origin_z,
                    direction_x, direction_y, direction_z, input ready);
    modport sink   (input valid, origin_x, origin_y, origin_z,
                    direction_x, direction_y, direction_z, output ready);
endinterface

interface obr_res_if import obr_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic                 hit;
    logic signed [TW-1:0] t_enter;
    logic signed [TW-1:0] t_exit;

    modport source (output valid, hit, t_enter, t_exit, input ready);
    modport sink   (input valid, hit, t_enter, t_exit, output ready);
endinterface

@@ src/oriented_box_ray_slab_test.sv @@
// top level of the oriented box ray slab test
//
//  channel  | dir | handshake                    | payload
//  i_ray    | in  | valid/ready                  | origin xyz Q10.10, direction xyz Q1.19
//  o_res    | out | valid/ready                  | hit, t_enter, t_exit Q6.25
//  apb      | in  | psel/penable/pwrite, pready  | six box registers at 8*i
//
// one ray per cycle while the skid stage is empty
// the per-axis divider pipeline produces one quotient bit per stage
// synchronous active-low reset clears valid bits and box registers
// a stall of the result channel fills a skid stage, then freezes the pipeline
module oriented_box_ray_slab_test import obr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    obr_ray_if.sink           i_ray,
    obr_res_if.source         o_res,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    typedef struct packed {
        logic                 hit;
        logic signed [TW-1:0] tn;
        logic signed [TW-1:0] tf;
    } t_ivl;

    typedef struct packed {
        logic                 hit;
        logic signed [TW-1:0] t_enter;
        logic signed [TW-1:0] t_exit;
    } t_res;

    function automatic t_vec3 unpack3(input logic [PACK_W-1:0] p);
        t_vec3 v;
        for (int k = 0; k < 3; k++) begin
            v[k] = $signed(p[k*CW +: CW]);
        end
        return v;
    endfunction

    function automatic t_ivl ivl_step(input t_ivl c, input t_axr x);
        t_ivl n;
        n = c;
        if (c.hit) begin
            if (x.par) begin
                n.hit = x.par_ok;
            end else if (($signed(x.t1) > $signed(c.tf)) || ($signed(x.t2) < $signed(c.tn))) begin
                n.hit = 1'b0;
            end else begin
                if ($signed(x.t2) < $signed(c.tf)) begin
                    n.tf = x.t2;
                end
                if ($signed(x.t1) > $signed(c.tn)) begin
                    n.tn = x.t1;
                end
            end
        end
        return n;
    endfunction

    logic [PACK_W-1:0] r_min;
    logic [PACK_W-1:0] r_max;
    logic [PACK_W-1:0] r_nrm [3];
    logic              r_bv;
    t_reg              sel;
    logic              wr;

    logic              en;
    logic              r_v [AXIS_LAT+1];
    t_vec3             r_org;
    t_vec3             r_dir;
    t_vec3             c_min;
    t_vec3             c_max;
    t_vec3             c_nrm [AXES];
    t_axr              axr [AXES];

    logic              r_iv_v [AXES];
    t_ivl              r_ivl [AXES];
    t_axr              r_ix [AXES][AXES];

    logic              push;
    t_res              pd;
    logic              r_ov;
    t_res              r_o;
    logic              r_sv;
    t_res              r_s;

    // configuration port
    assign sel    = t_reg'(paddr[ADDR_W-1:ADDR_LSB]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= '0;
            r_max <= '0;
            for (int a = 0; a < 3; a++) begin
                r_nrm[a] <= '0;
            end
            r_bv <= 1'b0;
        end else if (wr) begin
            unique case (sel)
                REG_MIN_CORNER: r_min    <= pwdata[PACK_W-1:0];
                REG_MAX_CORNER: r_max    <= pwdata[PACK_W-1:0];
                REG_NORMAL0:    r_nrm[0] <= pwdata[PACK_W-1:0];
                REG_NORMAL1:    r_nrm[1] <= pwdata[PACK_W-1:0];
                REG_NORMAL2:    r_nrm[2] <= pwdata[PACK_W-1:0];
                REG_BOX_VALID:  r_bv     <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (sel)
            REG_MIN_CORNER: prdata = DATA_W'(r_min);
            REG_MAX_CORNER: prdata = DATA_W'(r_max);
            REG_NORMAL0:    prdata = DATA_W'(r_nrm[0]);
            REG_NORMAL1:    prdata = DATA_W'(r_nrm[1]);
            REG_NORMAL2:    prdata = DATA_W'(r_nrm[2]);
            REG_BOX_VALID:  prdata = DATA_W'(r_bv);
            default:        prdata = '0;
        endcase
    end

    // input stage and valid line
    assign en          = !r_sv;
    assign i_ray.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s <= AXIS_LAT; s++) begin
                r_v[s] <= 1'b0;
            end
        end else if (en) begin
            r_v[0] <= i_ray.valid;
            for (int s = 1; s <= AXIS_LAT; s++) begin
                r_v[s] <= r_v[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_org[0] <= i_ray.origin_x;
            r_org[1] <= i_ray.origin_y;
            r_org[2] <= i_ray.origin_z;
            r_dir[0] <= i_ray.direction_x;
            r_dir[1] <= i_ray.direction_y;
            r_dir[2] <= i_ray.direction_z;
        end
    end

    // slabs
    always_comb begin
        c_min = unpack3(r_min);
        c_max = unpack3(r_max);
        for (int a = 0; a < AXES; a++) begin
            c_nrm[a] = unpack3(r_nrm[a]);
        end
    end

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        obr_axis u_axis (
            .i_clk (i_clk),
            .i_en  (en),
            .i_org (r_org),
            .i_dir (r_dir),
            .i_min (c_min),
            .i_max (c_max),
            .i_nrm (c_nrm[a]),
            .o_res (axr[a])
        );
    end

    // interval narrowing, one axis per stage
    for (genvar s = 0; s < AXES; s++) begin : g_ivl
        t_axr p_ix [AXES];
        t_ivl p_ivl;
        logic p_v;

        if (s == 0) begin : g_first
            assign p_ix  = axr;
            assign p_ivl = '{hit: r_bv, tn: T_MIN, tf: T_MAX};
            assign p_v   = r_v[AXIS_LAT];
        end else begin : g_next
            assign p_ix  = r_ix[s-1];
            assign p_ivl = r_ivl[s-1];
            assign p_v   = r_iv_v[s-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_iv_v[s] <= 1'b0;
            end else if (en) begin
                r_iv_v[s] <= p_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ix[s]  <= p_ix;
                r_ivl[s] <= ivl_step(p_ivl, p_ix[s]);
            end
        end
    end

    // output register with skid stage
    assign push = en && r_iv_v[AXES-1];

    always_comb begin
        pd.hit     = r_ivl[AXES-1].hit;
        pd.t_enter = r_ivl[AXES-1].hit ? r_ivl[AXES-1].tn : '0;
        pd.t_exit  = r_ivl[AXES-1].hit ? r_ivl[AXES-1].tf : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
            r_sv <= 1'b0;
        end else if (!r_ov || o_res.ready) begin
            if (r_sv) begin
                r_ov <= 1'b1;
                r_sv <= 1'b0;
            end else begin
                r_ov <= push;
            end
        end else if (push) begin
            r_sv <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_ov || o_res.ready) begin
            r_o <= r_sv ? r_s : pd;
        end else if (push) begin
            r_s <= pd;
        end
    end

    assign o_res.valid   = r_ov;
    assign o_res.hit     = r_o.hit;
    assign o_res.t_enter = r_o.t_enter;
    assign o_res.t_exit  = r_o.t_exit;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sv |-> r_ov)
        else $error("skid stage holds an item while the output register is empty");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && !o_res.ready && push) |=> r_sv)
        else $error("item pushed during output stall was not caught by the skid stage");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.hit) |-> (o_res.t_enter == '0 && o_res.t_exit == '0))
        else $error("missed ray carries nonzero parameters");
`endif

endmodule

@@ src/obr_axis.sv @@
// one slab: projections, pipelined divisions and plane parameters
module obr_axis import obr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_en,
    input  t_vec3 i_org,
    input  t_vec3 i_dir,
    input  t_vec3 i_min,
    input  t_vec3 i_max,
    input  t_vec3 i_nrm,
    output t_axr  o_res
);

    localparam int PW = 2 * CW;
    localparam int DW = PW + 2;
    localparam int MW = 2 * CW + 1;
    localparam int NW = MW + 2;
    localparam int AW = NW - 2;
    localparam int RW = DW - 2;

    typedef struct packed {
        logic [RW-1:0]        rem_lo;
        logic [RW-1:0]        rem_hi;
        logic [DIV_STEPS-1:0] q_lo;
        logic [DIV_STEPS-1:0] q_hi;
        logic [SAT_SH-1:0]    lo_lo;
        logic [SAT_SH-1:0]    lo_hi;
        logic [RW-1:0]        d;
        logic                 neg_lo;
        logic                 neg_hi;
        logic                 sat_lo;
        logic                 sat_hi;
        logic                 dneg;
        logic                 par;
        logic                 par_ok;
    } t_dv;

    function automatic logic [RW:0] div_bit(input logic [RW-1:0] rem,
                                            input logic [RW-1:0] d,
                                            input logic b);
        logic [RW:0] cat;
        logic [RW:0] dif;
        cat = {rem, b};
        dif = cat - {1'b0, d};
        if (cat >= {1'b0, d}) begin
            div_bit = {1'b1, dif[RW-1:0]};
        end else begin
            div_bit = {1'b0, cat[RW-1:0]};
        end
    endfunction

    function automatic logic signed [TW-1:0] to_tq(input logic [DIV_STEPS-1:0] q,
                                                   input logic neg, input logic sat);
        logic signed [TW-1:0] m;
        m = $signed({1'b0, q});
        if (sat) begin
            to_tq = neg ? T_MIN : T_MAX;
        end else begin
            to_tq = neg ? -m : m;
        end
    endfunction

    logic signed [CW:0]   dmn [3];
    logic signed [CW:0]   dmx [3];
    logic signed [PW-1:0] r_pd [3];
    logic signed [MW-1:0] r_pmn [3];
    logic signed [MW-1:0] r_pmx [3];
    logic signed [DW-1:0] r_dp;
    logic signed [NW-1:0] r_nmn;
    logic signed [NW-1:0] r_nmx;
    t_dv                  n_dv0;
    t_dv                  r_dv [DIV_STEPS+1];
    logic [DW-1:0]        dmag;
    logic [NW-1:0]        nmag_lo;
    logic [NW-1:0]        nmag_hi;
    logic signed [TW-1:0] t_lo;
    logic signed [TW-1:0] t_hi;

    // projections
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dmn[k] = (CW+1)'(i_min[k]) - (CW+1)'(i_org[k]);
            dmx[k] = (CW+1)'(i_max[k]) - (CW+1)'(i_org[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_pd[k]  <= i_nrm[k] * i_dir[k];
                r_pmn[k] <= dmn[k] * i_nrm[k];
                r_pmx[k] <= dmx[k] * i_nrm[k];
            end
            r_dp  <= DW'(r_pd[0]) + DW'(r_pd[1]) + DW'(r_pd[2]);
            r_nmn <= NW'(r_pmn[0]) + NW'(r_pmn[1]) + NW'(r_pmn[2]);
            r_nmx <= NW'(r_pmx[0]) + NW'(r_pmx[1]) + NW'(r_pmx[2]);
        end
    end

    // signs, magnitudes, overflow and first partial remainder
    always_comb begin
        dmag    = r_dp[DW-1] ? DW'(-r_dp) : DW'(r_dp);
        nmag_lo = r_nmn[NW-1] ? NW'(-r_nmn) : NW'(r_nmn);
        nmag_hi = r_nmx[NW-1] ? NW'(-r_nmx) : NW'(r_nmx);
        n_dv0        = '0;
        n_dv0.d      = dmag[RW-1:0];
        n_dv0.dneg   = r_dp[DW-1];
        n_dv0.par    = (r_dp == '0);
        n_dv0.par_ok = (r_nmn <= 0) && (r_nmx >= 0);
        n_dv0.neg_lo = r_nmn[NW-1] != r_dp[DW-1];
        n_dv0.neg_hi = r_nmx[NW-1] != r_dp[DW-1];
        n_dv0.sat_lo = (RW+SAT_SH)'(nmag_lo[AW-1:0]) >= {dmag[RW-1:0], {SAT_SH{1'b0}}};
        n_dv0.sat_hi = (RW+SAT_SH)'(nmag_hi[AW-1:0]) >= {dmag[RW-1:0], {SAT_SH{1'b0}}};
        n_dv0.rem_lo = RW'(nmag_lo[AW-1:SAT_SH]);
        n_dv0.rem_hi = RW'(nmag_hi[AW-1:SAT_SH]);
        n_dv0.lo_lo  = nmag_lo[SAT_SH-1:0];
        n_dv0.lo_hi  = nmag_hi[SAT_SH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dv[0] <= n_dv0;
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
        localparam int BI = DIV_STEPS - 1 - j - QSH;
        logic        b_lo;
        logic        b_hi;
        logic [RW:0] s_lo;
        logic [RW:0] s_hi;
        t_dv         n_dv;

        if (BI >= 0) begin : g_bring
            assign b_lo = r_dv[j].lo_lo[BI];
            assign b_hi = r_dv[j].lo_hi[BI];
        end else begin : g_zero
            assign b_lo = 1'b0;
            assign b_hi = 1'b0;
        end

        assign s_lo = div_bit(r_dv[j].rem_lo, r_dv[j].d, b_lo);
        assign s_hi = div_bit(r_dv[j].rem_hi, r_dv[j].d, b_hi);

        always_comb begin
            n_dv        = r_dv[j];
            n_dv.rem_lo = s_lo[RW-1:0];
            n_dv.rem_hi = s_hi[RW-1:0];
            n_dv.q_lo   = {r_dv[j].q_lo[DIV_STEPS-2:0], s_lo[RW]};
            n_dv.q_hi   = {r_dv[j].q_hi[DIV_STEPS-2:0], s_hi[RW]};
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[j+1] <= n_dv;
            end
        end
    end

    // sign, saturation and entry/exit order
    always_comb begin
        t_lo = to_tq(r_dv[DIV_STEPS].q_lo, r_dv[DIV_STEPS].neg_lo, r_dv[DIV_STEPS].sat_lo);
        t_hi = to_tq(r_dv[DIV_STEPS].q_hi, r_dv[DIV_STEPS].neg_hi, r_dv[DIV_STEPS].sat_hi);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_res.par    <= r_dv[DIV_STEPS].par;
            o_res.par_ok <= r_dv[DIV_STEPS].par_ok;
            o_res.t1     <= r_dv[DIV_STEPS].dneg ? t_hi : t_lo;
            o_res.t2     <= r_dv[DIV_STEPS].dneg ? t_lo : t_hi;
        end
    end

endmodule

@@ test/tb_oriented_box_ray_slab_test.sv @@
// testbench of the oriented box ray slab test: predicted hit and entry/exit parameters
module tb_oriented_box_ray_slab_test;
    import obr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int UNIT_NORMAL    = 1 << 19;
    localparam int UNIT_POINT     = 1 << 10;

    typedef struct {
        t_comp org [3];
        t_comp dir [3];
    } t_ray;

    typedef struct {
        logic                 hit;
        logic signed [TW-1:0] t_enter;
        logic signed [TW-1:0] t_exit;
    } t_slab_result;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    obr_ray_if ray_if ();
    obr_res_if res_if ();

    oriented_box_ray_slab_test dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ray   (ray_if.sink),
        .o_res   (res_if.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [PACK_W-1:0] box_min;
    logic [PACK_W-1:0] box_max;
    logic [PACK_W-1:0] box_normal [3];
    logic              box_ok;

    t_ray         rays_pending [$];
    t_slab_result slab_expected [$];
    int           fail_count;
    int           rays_sent;
    int           hits_seen;
    int           results_seen;
    int           idle_cycles;
    bit           ray_taken;
    bit           quiet;
    int           ray_gap;
    int           res_stall;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (quiet || r < 60) return 0;
        if (r < 92) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    function automatic longint part(logic [PACK_W-1:0] p, int k);
        logic signed [CW-1:0] c;
        c = p[CW*k +: CW];
        return longint'(c);
    endfunction

    function automatic logic [PACK_W-1:0] pack3(int x, int y, int z);
        logic [CW-1:0] a, b, c;
        a = x[CW-1:0];
        b = y[CW-1:0];
        c = z[CW-1:0];
        return {c, b, a};
    endfunction

    // truncated quotient in q6.25, saturated at both ends
    function automatic longint plane_param(longint num, longint den);
        bit                neg;
        longint unsigned   n, d, q, r;
        neg = (num < 0) != (den < 0);
        n = num < 0 ? longint'(-num) : num;
        d = den < 0 ? longint'(-den) : den;
        if (n >= (d << 6)) return neg ? longint'(T_MIN) : longint'(T_MAX);
        q = n / d;
        r = n % d;
        for (int i = 0; i < QSH; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r = r - d;
                q = q | 1;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_slab_result slab_predict(t_ray ray);
        t_slab_result res;
        longint tnear, tfar, dp, st, fmin, fmax, t1, t2, nk;
        bit hit;
        tnear = T_MIN;
        tfar  = T_MAX;
        hit   = box_ok;
        for (int a = 0; a < AXES; a++) begin
            if (hit) begin
                dp = 0; st = 0; fmin = 0; fmax = 0;
                for (int k = 0; k < 3; k++) begin
                    nk   = part(box_normal[a], k);
                    dp   += nk * longint'(ray.dir[k]);
                    st   += nk * longint'(ray.org[k]);
                    fmin += nk * part(box_min, k);
                    fmax += nk * part(box_max, k);
                end
                if (dp == 0) begin
                    if (st > fmax || st < fmin) hit = 0;
                end else begin
                    if (dp > 0) begin
                        t1 = plane_param(fmin - st, dp);
                        t2 = plane_param(fmax - st, dp);
                    end else begin
                        t2 = plane_param(fmin - st, dp);
                        t1 = plane_param(fmax - st, dp);
                    end
                    if (t1 > tfar || t2 < tnear) begin
                        hit = 0;
                    end else begin
                        if (t2 < tfar) tfar = t2;
                        if (t1 > tnear) tnear = t1;
                    end
                end
            end
        end
        res.hit     = hit;
        res.t_enter = hit ? tnear[TW-1:0] : '0;
        res.t_exit  = hit ? tfar[TW-1:0] : '0;
        return res;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch on %s at %0t: got %0d, expected %0d", what, $time, got, want);
        fail_count++;
    endtask

    // monitor and predictor at the rising edge
    always @(posedge i_clk) begin
        t_ray         r;
        t_slab_result e;
        ray_taken = 0;
        if (i_rst_n) begin
            if (ray_if.valid && ray_if.ready) begin
                r.org[0] = ray_if.origin_x;
                r.org[1] = ray_if.origin_y;
                r.org[2] = ray_if.origin_z;
                r.dir[0] = ray_if.direction_x;
                r.dir[1] = ray_if.direction_y;
                r.dir[2] = ray_if.direction_z;
                slab_expected.insert(slab_expected.size(), slab_predict(r));
                ray_taken = 1;
                rays_sent++;
            end
            if (res_if.valid && res_if.ready) begin
                results_seen++;
                if (slab_expected.size() == 0) begin
                    report_mismatch("result count", results_seen, rays_sent);
                end else begin
                    e = slab_expected.pop_front();
                    if (res_if.hit) hits_seen++;
                    if (res_if.hit !== e.hit) report_mismatch("hit", res_if.hit, e.hit);
                    if (res_if.t_enter !== e.t_enter)
                        report_mismatch("t_enter", res_if.t_enter, e.t_enter);
                    if (res_if.t_exit !== e.t_exit)
                        report_mismatch("t_exit", res_if.t_exit, e.t_exit);
                end
            end
            if (ray_taken || (res_if.valid && res_if.ready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog expired with %0d results outstanding", slab_expected.size());
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ray driver at the falling edge
    always @(negedge i_clk) begin
        t_ray r;
        if (!i_rst_n) begin
            ray_if.valid <= 1'b0;
        end else if (!ray_if.valid || ray_taken) begin
            if (ray_gap > 0) begin
                ray_gap--;
                ray_if.valid <= 1'b0;
            end else if (rays_pending.size() > 0) begin
                r = rays_pending.pop_front();
                ray_if.origin_x    <= r.org[0];
                ray_if.origin_y    <= r.org[1];
                ray_if.origin_z    <= r.org[2];
                ray_if.direction_x <= r.dir[0];
                ray_if.direction_y <= r.dir[1];
                ray_if.direction_z <= r.dir[2];
                ray_if.valid       <= 1'b1;
                ray_gap = pick_gap();
            end else begin
                ray_if.valid <= 1'b0;
            end
        end
    end

    // result stalls at the falling edge
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else if (res_stall > 0) begin
            res_stall--;
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= 1'b1;
            res_stall = pick_gap();
        end
    end

    task automatic write_reg(t_reg idx, logic [DATA_W-1:0] val);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, {ADDR_LSB{1'b0}}};
        pwdata  <= val;
        @(negedge i_clk);
        penable <= 1'b1;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_CORNER: box_min       = val[PACK_W-1:0];
            REG_MAX_CORNER: box_max       = val[PACK_W-1:0];
            REG_NORMAL0:    box_normal[0] = val[PACK_W-1:0];
            REG_NORMAL1:    box_normal[1] = val[PACK_W-1:0];
            REG_NORMAL2:    box_normal[2] = val[PACK_W-1:0];
            REG_BOX_VALID:  box_ok        = val[0];
            default: ;
        endcase
    endtask

    task automatic set_box(logic [PACK_W-1:0] mn, logic [PACK_W-1:0] mx,
                           logic [PACK_W-1:0] n0, logic [PACK_W-1:0] n1,
                           logic [PACK_W-1:0] n2, logic ok);
        write_reg(REG_MIN_CORNER, {1'b0, mn});
        write_reg(REG_MAX_CORNER, {1'b0, mx});
        write_reg(REG_NORMAL0, {1'b0, n0});
        write_reg(REG_NORMAL1, {1'b0, n1});
        write_reg(REG_NORMAL2, {1'b0, n2});
        write_reg(REG_BOX_VALID, {63'd0, ok});
    endtask

    task automatic wait_drained();
        while (rays_pending.size() > 0 || ray_if.valid || slab_expected.size() > 0)
            @(posedge i_clk);
        repeat (AXIS_LAT + AXES + 6) @(posedge i_clk);
    endtask

    task automatic add_ray(int ox, int oy, int oz, int dx, int dy, int dz);
        t_ray r;
        r.org[0] = ox[CW-1:0]; r.org[1] = oy[CW-1:0]; r.org[2] = oz[CW-1:0];
        r.dir[0] = dx[CW-1:0]; r.dir[1] = dy[CW-1:0]; r.dir[2] = dz[CW-1:0];
        rays_pending.insert(rays_pending.size(), r);
    endtask

    function automatic int rnd_comp();
        int v;
        v = $urandom_range(2097151);
        return v - 1048576;
    endfunction

    // rays aimed near the box, with some axis-parallel and some fully random
    task automatic add_random_rays(int count, int spread);
        int ox, oy, oz, dx, dy, dz, kind;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(9);
            if (kind < 2) begin
                add_ray(rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp(), rnd_comp());
            end else begin
                ox = $urandom_range(2 * spread) - spread;
                oy = $urandom_range(2 * spread) - spread;
                oz = $urandom_range(2 * spread) - spread;
                dx = $urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL;
                dy = $urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL;
                dz = $urandom_range(2 * UNIT_NORMAL) - UNIT_NORMAL;
                if (kind == 2) dx = 0;
                if (kind == 3) begin dy = 0; dz = 0; end
                if (kind == 4) dx = rnd_comp();
                add_ray(ox, oy, oz, dx, dy, dz);
            end
        end
    endtask

    initial begin
        int b, u;
        logic [PACK_W-1:0] ax, ay, az;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        ray_if.valid = 0; res_if.ready = 0;
        ray_if.origin_x = '0; ray_if.origin_y = '0; ray_if.origin_z = '0;
        ray_if.direction_x = '0; ray_if.direction_y = '0; ray_if.direction_z = '0;
        box_min = '0; box_max = '0; box_ok = 0;
        for (int a = 0; a < 3; a++) box_normal[a] = '0;
        fail_count = 0; rays_sent = 0; hits_seen = 0; results_seen = 0;
        idle_cycles = 0; ray_gap = 0; res_stall = 0; quiet = 0;
        i_rst_n = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset state: box invalid, every ray misses
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(-1048576, 1048575, -1048576, 1048575, -1048576, 1048575);
        wait_drained();

        b  = 10 * UNIT_POINT;
        u  = UNIT_NORMAL;
        ax = pack3(u, 0, 0);
        ay = pack3(0, u, 0);
        az = pack3(0, 0, u);
        set_box(pack3(-b, -b, -b), pack3(b, b, b), ax, ay, az, 1'b1);
        quiet = 1;
        add_ray(-2 * b, 0, 0, u, 0, 0);
        add_ray(2 * b, 0, 0, -u, 0, 0);
        add_ray(0, 0, 0, 0, 0, 0);
        add_ray(0, 2 * b, 0, 0, 0, 0);
        add_ray(b, -b, b, 0, 0, 0);
        add_ray(-2 * b, 2 * b, 0, u, 0, 0);
        add_ray(-2 * b, -2 * b, -2 * b, u, u, u);
        add_ray(-2 * b, 0, 0, 1, 0, 0);
        add_ray(0, 0, 0, -1, 1, -1);
        add_ray(1048575, 1048575, 1048575, -1048576, -1048576, -1048576);
        add_ray(-1048576, -1048576, -1048576, 1048575, 1048575, 1048575);
        add_ray(-1048576, 0, 0, 1048575, 0, 0);
        add_ray(0, -2 * b, 0, 0, u, -u);
        add_ray(3 * b, 0, 0, u, 0, 0);
        add_ray(0, 0, 0, u, u, 0);
        wait_drained();
        quiet = 0;
        add_random_rays(150, 30 * UNIT_POINT);
        wait_drained();

        // inverted corners
        set_box(pack3(b, b, b), pack3(-b, -b, -b), ax, ay, az, 1'b1);
        add_ray(0, 0, 0, u, u, u);
        add_ray(0, 0, 0, 0, 0, 0);
        add_random_rays(120, 30 * UNIT_POINT);
        wait_drained();

        // rotated box in the xy plane
        set_box(pack3(-b, -2 * b, -b), pack3(3 * b, b, b),
                pack3(370728, 370728, 0), pack3(-370728, 370728, 0), az, 1'b1);
        add_random_rays(150, 40 * UNIT_POINT);
        wait_drained();

        // extreme registers
        set_box(pack3(-1048576, -1048576, -1048576), pack3(1048575, 1048575, 1048575),
                pack3(-1048576, -1048576, -1048576), pack3(1048575, 1048575, 1048575),
                pack3(-1048576, 1048575, 0), 1'b1);
        add_random_rays(120, 1000 * UNIT_POINT);
        wait_drained();

        // all ones in every register bit
        set_box({PACK_W{1'b1}}, {PACK_W{1'b1}}, {PACK_W{1'b1}}, {PACK_W{1'b1}},
                {PACK_W{1'b1}}, 1'b1);
        add_random_rays(60, 4 * UNIT_POINT);
        wait_drained();

        // random normals
        for (int p = 0; p < 3; p++) begin
            set_box(pack3(-b, -b, -b), pack3(b, 2 * b, b),
                    pack3(rnd_comp(), rnd_comp(), rnd_comp()),
                    pack3(rnd_comp(), rnd_comp(), rnd_comp()),
                    pack3(rnd_comp(), rnd_comp(), rnd_comp()), 1'b1);
            add_random_rays(60, 20 * UNIT_POINT);
            wait_drained();
        end

        // box valid cleared again
        set_box(pack3(-b, -b, -b), pack3(b, b, b), ax, ay, az, 1'b0);
        add_random_rays(40, 20 * UNIT_POINT);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("rays: %0d sent, %0d results checked, %0d hits", rays_sent, results_seen,
                 hits_seen);
        $display("box settings: reset, axis aligned, inverted, rotated, extreme, random");
        if (fail_count == 0 && slab_expected.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
